>>> rtl/core/cle_pkg.sv
package cle_pkg;

   // Item kinds on the request channel
   typedef enum logic {
      OP_KEY  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // Echo action reported with each key
   typedef enum logic [1:0] {
      ECHO_NONE  = 2'd0,
      ECHO_CHAR  = 2'd1,
      ECHO_ERASE = 2'd2
   } echo_kind_type;

   // Control keys
   localparam logic [7:0] KEY_NUL  = 8'h00;
   localparam logic [7:0] KEY_EOT  = 8'h04;
   localparam logic [7:0] KEY_BS   = 8'h08;
   localparam logic [7:0] KEY_LF   = 8'h0a;
   localparam logic [7:0] KEY_CR   = 8'h0d;
   localparam logic [7:0] KEY_KILL = 8'h15;
   localparam logic [7:0] KEY_DEL  = 8'h7f;

   // Result of the edit decision, less the byte fetched from the ring
   typedef struct packed {
      echo_kind_type echo_kind;
      logic [7:0]    echo_char;
      logic [7:0]    erase_count;
      logic          read_valid;
   } result_type;

endpackage

>>> rtl/core/console_line_editor_ring.sv
// Channel | Direction | Ports
// --------+-----------+----------------------------------------------------
// req     | in        | req_valid, req_ready, req_op, req_key
// rsp     | out       | rsp_valid, rsp_ready, rsp_echo_kind, rsp_echo_char,
//         |           | rsp_erase_count, rsp_read_valid, rsp_read_char
//
// One word is taken per cycle while req_ready is high. The line memory's
// registered read port and stage one both load at the accepting edge, and
// the output register loads from stage one once it is free, which raises
// rsp_valid. Indices live in flops and are updated at accept. Reset clears
// the read, commit and edit indices; the line memory is not cleared and
// needs no sweep. A stalled rsp side backs up through the two stages, and
// req_ready drops only once both hold a result.
module console_line_editor_ring #(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [7:0]             req_key,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_echo_kind,
   output logic [7:0]             rsp_echo_char,
   output logic [7:0]             rsp_erase_count,
   output logic                   rsp_read_valid,
   output logic [7:0]             rsp_read_char
);

   import cle_pkg::*;

   localparam int SLOT_W = $clog2(BUFFER_DEPTH);

   logic              accept;
   logic              s1_adv;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [SLOT_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   result_type        result;

   logic              s1_valid_ff, s1_valid_in;
   result_type        s1_result_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_result_ff;
   logic [7:0]        out_char_ff;

   // Handshake: stage one moves on when the output register is free
   assign s1_adv    = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   cle_edit_ctrl #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .op     (op_type'(req_op)),
      .key    (req_key),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .result (result)
   );

   cle_ring_mem #(
      .DEPTH(BUFFER_DEPTH)
   ) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign s1_valid_in  = req_ready ? accept : s1_valid_ff;
   assign out_valid_in = s1_adv ? s1_valid_ff : out_valid_ff;

   // Hold control state of both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Stage one: keep the decision while the memory fetch completes
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_result_ff <= result;
      end
   end

   // Output register: merge the fetched byte, drop it on non-reads
   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         out_result_ff <= s1_result_ff;
         out_char_ff   <= s1_result_ff.read_valid ? rd_data : 8'd0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_echo_kind   = out_result_ff.echo_kind;
   assign rsp_echo_char   = out_result_ff.echo_char;
   assign rsp_erase_count = out_result_ff.erase_count;
   assign rsp_read_valid  = out_result_ff.read_valid;
   assign rsp_read_char   = out_char_ff;

   // Back-pressure only when both stages are occupied
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && out_valid_ff && !rsp_ready))
      else $error("request stalled with a free stage");

   // An accepted word reaches stage one
   a_accept_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted word lost before stage one");

   // A waiting result is not overwritten
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(out_char_ff)))
      else $error("stalled result changed");

endmodule

>>> rtl/core/cle_ring_mem.sv
module cle_ring_mem #(
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write one byte of the line
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Fetch one committed byte, hold it until the next fetch
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/cle_edit_ctrl.sv
module cle_edit_ctrl #(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  cle_pkg::op_type                 op,
   input  logic [7:0]                      key,
   output logic                            wr_en,
   output logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
   output logic [7:0]                      wr_data,
   output logic                            rd_en,
   output logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
   output cle_pkg::result_type             result
);

   import cle_pkg::*;

   localparam int SLOT_W = $clog2(BUFFER_DEPTH);
   localparam int IDX_W  = $clog2(2 * BUFFER_DEPTH);
   localparam logic [IDX_W:0]   IDX_MOD = (IDX_W + 1)'(2 * BUFFER_DEPTH);
   localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(2 * BUFFER_DEPTH - 1);
   localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(BUFFER_DEPTH);
   localparam logic [IDX_W-1:0] FILL_I  = IDX_W'(BUFFER_DEPTH - 1);

   // Modular distance a - b over twice the ring depth
   function automatic logic [IDX_W-1:0] idx_diff(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] d;
      d = {1'b0, a} - {1'b0, b};
      if (d[IDX_W]) begin
         d = d + IDX_MOD;
      end
      return d[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
      return (a == IDX_TOP) ? '0 : a + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] a);
      return (a == '0) ? IDX_TOP : a - IDX_W'(1);
   endfunction

   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] a);
      logic [IDX_W-1:0] s;
      s = (a >= DEPTH_I) ? a - DEPTH_I : a;
      return s[SLOT_W-1:0];
   endfunction

   logic [IDX_W-1:0] read_ff, read_in;
   logic [IDX_W-1:0] commit_ff, commit_in;
   logic [IDX_W-1:0] edit_ff, edit_in;

   logic [IDX_W-1:0] edit_read_diff;
   logic [IDX_W-1:0] edit_commit_diff;
   logic [IDX_W-1:0] commit_read_diff;
   logic [7:0]       mapped;
   logic             store;
   logic             ring_fills;
   logic             hit;

   assign edit_read_diff   = idx_diff(edit_ff, read_ff);
   assign edit_commit_diff = idx_diff(edit_ff, commit_ff);
   assign commit_read_diff = idx_diff(commit_ff, read_ff);
   assign mapped           = (key == KEY_CR) ? KEY_LF : key;
   assign hit              = (read_ff != commit_ff);
   assign ring_fills       = (edit_read_diff == FILL_I);

   // Decide the edit action and the next indices
   always_comb begin
      read_in            = read_ff;
      commit_in          = commit_ff;
      edit_in            = edit_ff;
      store              = 1'b0;
      result.echo_kind   = ECHO_NONE;
      result.echo_char   = '0;
      result.erase_count = '0;
      result.read_valid  = 1'b0;
      priority if (op == OP_READ) begin
         if (hit) begin
            result.read_valid = 1'b1;
            read_in           = idx_inc(read_ff);
         end
      end else if (key == KEY_KILL) begin
         if (edit_commit_diff != '0) begin
            result.echo_kind   = ECHO_ERASE;
            result.erase_count = 8'(edit_commit_diff);
            edit_in            = commit_ff;
         end
      end else if (key == KEY_BS || key == KEY_DEL) begin
         if (edit_ff != commit_ff) begin
            result.echo_kind   = ECHO_ERASE;
            result.erase_count = 8'd1;
            edit_in            = idx_dec(edit_ff);
         end
      end else if (key != KEY_NUL && edit_read_diff < DEPTH_I) begin
         store            = 1'b1;
         result.echo_kind = ECHO_CHAR;
         result.echo_char = mapped;
         edit_in          = idx_inc(edit_ff);
         if (mapped == KEY_LF || mapped == KEY_EOT || ring_fills) begin
            commit_in = idx_inc(edit_ff);
         end
      end else begin
         store = 1'b0;
      end
   end

   // Drive the ring ports
   assign wr_en   = accept && store;
   assign wr_addr = slot_of(edit_ff);
   assign wr_data = mapped;
   assign rd_en   = accept && (op == OP_READ) && hit;
   assign rd_addr = slot_of(read_ff);

   // Advance the indices on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         read_ff   <= '0;
         commit_ff <= '0;
         edit_ff   <= '0;
      end else if (accept) begin
         read_ff   <= read_in;
         commit_ff <= commit_in;
         edit_ff   <= edit_in;
      end
   end

   // The typed line never exceeds the ring
   a_ring_bound: assert property (@(posedge clock) disable iff (reset)
      edit_read_diff <= DEPTH_I)
      else $error("line extends beyond ring depth");

   // Committed bytes lie inside the typed region
   a_commit_order: assert property (@(posedge clock) disable iff (reset)
      commit_read_diff <= edit_read_diff)
      else $error("commit index outside read..edit");

   // A store that fills the ring commits the whole line
   a_full_commits: assert property (@(posedge clock) disable iff (reset)
      (wr_en && ring_fills) |=> (commit_ff == edit_ff))
      else $error("full ring left uncommitted");

   // A fetch never targets the slot being written
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (hit && edit_read_diff != DEPTH_I) |-> (wr_addr != rd_addr))
      else $error("read and edit slots collide");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import cle_pkg::*;

   localparam int RING_DEPTH  = 128;
   localparam int IDX_W       = $clog2(RING_DEPTH) + 1;
   localparam int SLOT_W      = $clog2(RING_DEPTH);
   localparam int WORD_COUNT  = 1550;
   localparam int STALL_LIMIT = 5000;

   // One result word as seen on the rsp channel
   typedef struct packed {
      echo_kind_type kind;
      logic [7:0]    shown;
      logic [7:0]    erased;
      logic          got;
      logic [7:0]    fetched;
   } console_echo_type;

   // One row of the directed stimulus; typed rows carry their own expectation
   typedef struct {
      op_type           op;
      logic [7:0]       key;
      bit               typed;
      console_echo_type want;
   } stim_row_type;

   localparam console_echo_type QUIET = '0;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic             req_op;
   logic [7:0]       req_key;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [1:0]       rsp_echo_kind;
   logic [7:0]       rsp_echo_char;
   logic [7:0]       rsp_erase_count;
   logic             rsp_read_valid;
   logic [7:0]       rsp_read_char;

   // Predictor state: the line ring and its three indices
   logic [7:0]       line_ring [RING_DEPTH];
   logic [IDX_W-1:0] read_at;
   logic [IDX_W-1:0] commit_at;
   logic [IDX_W-1:0] edit_at;

   console_echo_type pending_echoes [$];
   int               words_sent;
   int               mismatches;
   int               quiet_cycles;
   bit               no_idle;
   stim_row_type     plan [24];

   console_line_editor_ring #(
      .BUFFER_DEPTH(RING_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_echo_kind  (rsp_echo_kind),
      .rsp_echo_char  (rsp_echo_char),
      .rsp_erase_count(rsp_erase_count),
      .rsp_read_valid (rsp_read_valid),
      .rsp_read_char  (rsp_read_char)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one word to the line discipline and return the echo it causes
   function automatic console_echo_type edit_line(op_type op, logic [7:0] key);
      console_echo_type r;
      logic [7:0]       c;
      logic [IDX_W-1:0] fill;
      r    = QUIET;
      fill = edit_at - read_at;
      if (op == OP_READ) begin
         if (read_at != commit_at) begin
            r.got     = 1'b1;
            r.fetched = line_ring[read_at[SLOT_W-1:0]];
            read_at   = read_at + 1'b1;
         end
      end else if (key == KEY_KILL) begin
         if (edit_at != commit_at) begin
            r.kind   = ECHO_ERASE;
            r.erased = 8'(IDX_W'(edit_at - commit_at));
            edit_at  = commit_at;
         end
      end else if (key == KEY_BS || key == KEY_DEL) begin
         if (edit_at != commit_at) begin
            edit_at  = edit_at - 1'b1;
            r.kind   = ECHO_ERASE;
            r.erased = 8'd1;
         end
      end else if (key != KEY_NUL && fill < IDX_W'(RING_DEPTH)) begin
         c = (key == KEY_CR) ? KEY_LF : key;
         line_ring[edit_at[SLOT_W-1:0]] = c;
         edit_at = edit_at + 1'b1;
         r.kind  = ECHO_CHAR;
         r.shown = c;
         fill    = edit_at - read_at;
         // commit on end of line, end of file or a ring that just filled
         if (c == KEY_LF || c == KEY_EOT || fill == IDX_W'(RING_DEPTH))
            commit_at = edit_at;
      end
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // Offer one word, idling at random first, and queue its expected echo
   task automatic send_word(op_type op, logic [7:0] key, bit typed = 1'b0,
                            console_echo_type want = QUIET);
      console_echo_type predicted;
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 17) begin
         req_valid = 1'b0;
         req_op    = 1'($urandom_range(0, 1));
         req_key   = 8'($urandom_range(0, 255));
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_op    = op;
      req_key   = key;
      do @(posedge clock); while (!req_ready);
      predicted = edit_line(op, key);
      pending_echoes.push_back(typed ? want : predicted);
      words_sent++;
      no_idle = (words_sent >= 500 && words_sent < 800);
   endtask

   // Type a random key other than a control that edits or commits
   function automatic logic [7:0] plain_key();
      logic [7:0] k;
      do k = 8'($urandom_range(1, 255));
      while (k == KEY_BS || k == KEY_DEL || k == KEY_KILL ||
             k == KEY_CR || k == KEY_LF || k == KEY_EOT);
      return k;
   endfunction

   // Stall the rsp side at random, except in the calm stretch
   always @(negedge clock) begin
      if (reset)
         rsp_ready = 1'b0;
      else
         rsp_ready = no_idle || ($urandom_range(0, 99) >= 17);
   end

   // Check each accepted result and watch for a stuck channel
   always @(posedge clock) begin
      console_echo_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_echoes.size() == 0) begin
            mismatches++;
            $display("%0t: result expected none, got kind %0h char %0h",
                     $time, rsp_echo_kind, rsp_echo_char);
         end else begin
            want = pending_echoes.pop_front();
            check_field("echo_kind",   want.kind,    rsp_echo_kind);
            check_field("echo_char",   want.shown,   rsp_echo_char);
            check_field("erase_count", want.erased,  rsp_erase_count);
            check_field("read_valid",  want.got,     rsp_read_valid);
            check_field("read_char",   want.fetched, rsp_read_char);
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int pick;
      int len;
      int episode;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = OP_KEY;
      req_key      = KEY_NUL;
      rsp_ready    = 1'b0;
      words_sent   = 0;
      mismatches   = 0;
      quiet_cycles = 0;
      no_idle      = 1'b0;
      read_at      = '0;
      commit_at    = '0;
      edit_at      = '0;

      plan = '{
         '{OP_READ, KEY_NUL,  1'b1, QUIET},
         '{OP_KEY,  KEY_BS,   1'b1, QUIET},
         '{OP_KEY,  KEY_KILL, 1'b1, QUIET},
         '{OP_KEY,  KEY_NUL,  1'b1, QUIET},
         '{OP_KEY,  KEY_DEL,  1'b1, QUIET},
         '{OP_KEY,  8'h61,    1'b1, {ECHO_CHAR,  8'h61,  8'h00, 1'b0, 8'h00}},
         '{OP_KEY,  8'hff,    1'b1, {ECHO_CHAR,  8'hff,  8'h00, 1'b0, 8'h00}},
         '{OP_KEY,  KEY_DEL,  1'b1, {ECHO_ERASE, 8'h00,  8'h01, 1'b0, 8'h00}},
         '{OP_KEY,  8'h80,    1'b1, {ECHO_CHAR,  8'h80,  8'h00, 1'b0, 8'h00}},
         '{OP_KEY,  8'h01,    1'b1, {ECHO_CHAR,  8'h01,  8'h00, 1'b0, 8'h00}},
         '{OP_KEY,  KEY_KILL, 1'b1, {ECHO_ERASE, 8'h00,  8'h03, 1'b0, 8'h00}},
         '{OP_KEY,  KEY_CR,   1'b1, {ECHO_CHAR,  KEY_LF, 8'h00, 1'b0, 8'h00}},
         '{OP_READ, 8'hff,    1'b1, {ECHO_NONE,  8'h00,  8'h00, 1'b1, KEY_LF}},
         '{OP_READ, KEY_NUL,  1'b1, QUIET},
         '{OP_KEY,  8'h78,    1'b0, QUIET},
         '{OP_KEY,  KEY_EOT,  1'b0, QUIET},
         '{OP_READ, KEY_NUL,  1'b0, QUIET},
         '{OP_READ, KEY_NUL,  1'b0, QUIET},
         '{OP_KEY,  8'h7e,    1'b0, QUIET},
         '{OP_KEY,  KEY_NUL,  1'b0, QUIET},
         '{OP_KEY,  KEY_BS,   1'b0, QUIET},
         '{OP_READ, KEY_NUL,  1'b0, QUIET},
         '{OP_KEY,  KEY_LF,   1'b0, QUIET},
         '{OP_READ, KEY_NUL,  1'b0, QUIET}
      };

      // hold reset, then release it on a falling edge
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed words
      foreach (plan[i])
         send_word(plan[i].op, plan[i].key, plan[i].typed, plan[i].want);

      // random episodes: mostly edited lines followed by reads
      episode = 0;
      while (words_sent < WORD_COUNT) begin
         pick = $urandom_range(0, 99);
         if (episode == 3 || episode == 25 || pick < 3) begin
            // flood the ring without reading so it can fill and drop keys
            len = $urandom_range(125, 140);
            repeat (len) send_word(OP_KEY, plain_key());
            send_word(OP_KEY, KEY_KILL);
            send_word(OP_KEY, KEY_BS);
            repeat ($urandom_range(120, 140)) send_word(OP_READ, 8'($urandom_range(0, 255)));
         end else if (pick < 65) begin
            // edit one line, end it, then read some of it back
            len = $urandom_range(1, 30);
            repeat (len) begin
               pick = $urandom_range(0, 99);
               if (pick < 5)
                  send_word(OP_KEY, KEY_BS);
               else if (pick < 9)
                  send_word(OP_KEY, KEY_DEL);
               else if (pick < 12)
                  send_word(OP_KEY, KEY_KILL);
               else if (pick < 14)
                  send_word(OP_KEY, KEY_NUL);
               else
                  send_word(OP_KEY, plain_key());
            end
            pick = $urandom_range(0, 2);
            send_word(OP_KEY, pick == 0 ? KEY_CR : (pick == 1 ? KEY_LF : KEY_EOT));
            repeat ($urandom_range(0, len + 5)) send_word(OP_READ, 8'($urandom_range(0, 255)));
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 20)) send_word(OP_READ, 8'($urandom_range(0, 255)));
         end else begin
            // noise: any op, any key
            repeat ($urandom_range(1, 20))
               send_word(op_type'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
         episode++;
      end

      // drain the pipeline
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_echoes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> files.f
rtl/core/cle_pkg.sv
rtl/core/cle_ring_mem.sv
rtl/core/cle_edit_ctrl.sv
rtl/core/console_line_editor_ring.sv
tb/sv/testbench.sv
